[sv/tke_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key escape encoder package
// Item types, key codes and shared constants of the key escape encoder.
// ----------------------------------------------------------------------------
package tke_pkg;

  localparam int MAX_TEXT_BYTES = 4;
  localparam int SEQ_MAX        = 7;
  localparam int SEQ_LEN_W      = 3;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] KEY_UP     = 8'h80;
  localparam logic [7:0] KEY_INS    = 8'h86;
  localparam logic [7:0] KEY_F1     = 8'h8A;
  localparam logic [7:0] KEY_F5     = 8'h8E;
  localparam logic [7:0] KEY_REVTAB = 8'h96;
  localparam logic [7:0] KEY_TAB    = 8'h97;
  localparam logic [7:0] KEY_ENTER  = 8'h98;
  localparam logic [7:0] KEY_BKSP   = 8'h99;
  localparam logic [7:0] KEY_ESC    = 8'h9A;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic [7:0]  key_code;
    logic [2:0]  modifiers;
    logic [31:0] text_bytes;
    logic [2:0]  text_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [SEQ_LEN_W-1:0]    len;
  } seq_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

[sv/tke_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key escape encoder front end
// Classifies one key event and builds its complete byte sequence.
// ----------------------------------------------------------------------------
module tke_front (
  input  logic              app_cursor_mode,
  input  tke_pkg::in_item_t in_item,
  output tke_pkg::seq_t     seq
);
  import tke_pkg::*;

  function automatic logic [7:0] cursor_final(input logic [7:0] k);
    unique case (k[2:0])
      3'd0:    cursor_final = 8'h41;
      3'd1:    cursor_final = 8'h42;
      3'd2:    cursor_final = 8'h43;
      3'd3:    cursor_final = 8'h44;
      3'd4:    cursor_final = 8'h48;
      default: cursor_final = 8'h46;
    endcase
  endfunction

  // Upper byte is the tens digit, or zero when the code has one digit.
  function automatic logic [15:0] tilde_digits(input logic [7:0] k);
    unique case (k)
      8'h86:   tilde_digits = {8'h00, 8'h32};
      8'h87:   tilde_digits = {8'h00, 8'h33};
      8'h88:   tilde_digits = {8'h00, 8'h35};
      8'h89:   tilde_digits = {8'h00, 8'h36};
      8'h8E:   tilde_digits = {8'h31, 8'h35};
      8'h8F:   tilde_digits = {8'h31, 8'h37};
      8'h90:   tilde_digits = {8'h31, 8'h38};
      8'h91:   tilde_digits = {8'h31, 8'h39};
      8'h92:   tilde_digits = {8'h32, 8'h30};
      8'h93:   tilde_digits = {8'h32, 8'h31};
      8'h94:   tilde_digits = {8'h32, 8'h33};
      default: tilde_digits = {8'h32, 8'h34};
    endcase
  endfunction

  // Top bit flags a key that has a control code.
  function automatic logic [8:0] ctrl_code(input logic [7:0] k);
    if (k >= 8'h41 && k <= 8'h5A) begin
      ctrl_code = {1'b1, k - 8'h40};
    end else begin
      unique case (k)
        8'h20, 8'h40, 8'h32: ctrl_code = {1'b1, 8'h00};
        8'h5B, 8'h33:        ctrl_code = {1'b1, 8'h1B};
        8'h5C, 8'h34:        ctrl_code = {1'b1, 8'h1C};
        8'h5D, 8'h35:        ctrl_code = {1'b1, 8'h1D};
        8'h5E, 8'h36:        ctrl_code = {1'b1, 8'h1E};
        8'h5F, 8'h2D, 8'h37: ctrl_code = {1'b1, 8'h1F};
        8'h3F, 8'h2F, 8'h38: ctrl_code = {1'b1, 8'h7F};
        default:             ctrl_code = {1'b0, 8'h00};
      endcase
    end
  endfunction

  logic [7:0]           key;
  logic                 shift, alt, ctrl, modified;
  logic [7:0]           mod_char;
  logic [15:0]          digits;
  logic [8:0]           cc;
  logic                 text_ok;
  logic                 have_base;
  logic [SEQ_LEN_W-1:0] n;

  assign key      = in_item.key_code;
  assign shift    = in_item.modifiers[0];
  assign alt      = in_item.modifiers[1];
  assign ctrl     = in_item.modifiers[2];
  assign modified = (in_item.modifiers != 3'd0);
  assign mod_char = CH_ONE + {5'd0, in_item.modifiers};
  assign digits   = tilde_digits(key);
  assign cc       = ctrl_code(key);
  assign text_ok  = (in_item.text_len >= 3'd1) &&
                    ({29'd0, in_item.text_len} <= 32'(MAX_TEXT_BYTES));

  always_comb begin
    seq       = '0;
    n         = '0;
    have_base = (key == KEY_ENTER) || (key == KEY_BKSP) || (key == KEY_TAB) ||
                (key == KEY_ESC) || (ctrl && cc[8]) || text_ok;
    priority if ((key >= KEY_UP && key < KEY_INS) || (key >= KEY_F1 && key < KEY_F5)) begin
      seq.bytes[n] = CH_ESC; n = n + 1'b1;
      if (modified) begin
        seq.bytes[n] = CH_LBRK;  n = n + 1'b1;
        seq.bytes[n] = CH_ONE;   n = n + 1'b1;
        seq.bytes[n] = CH_SEMI;  n = n + 1'b1;
        seq.bytes[n] = mod_char; n = n + 1'b1;
      end else if (key >= KEY_F1 || app_cursor_mode) begin
        seq.bytes[n] = CH_O; n = n + 1'b1;
      end else begin
        seq.bytes[n] = CH_LBRK; n = n + 1'b1;
      end
      if (key >= KEY_F1) begin
        seq.bytes[n] = CH_P + (key - KEY_F1);
      end else begin
        seq.bytes[n] = cursor_final(key);
      end
      n = n + 1'b1;
    end else if (key >= KEY_INS && key < KEY_REVTAB) begin
      seq.bytes[n] = CH_ESC;  n = n + 1'b1;
      seq.bytes[n] = CH_LBRK; n = n + 1'b1;
      if (digits[15:8] != 8'h00) begin
        seq.bytes[n] = digits[15:8]; n = n + 1'b1;
      end
      seq.bytes[n] = digits[7:0]; n = n + 1'b1;
      if (modified) begin
        seq.bytes[n] = CH_SEMI;  n = n + 1'b1;
        seq.bytes[n] = mod_char; n = n + 1'b1;
      end
      seq.bytes[n] = CH_TILDE; n = n + 1'b1;
    end else if (key == KEY_REVTAB || (key == KEY_TAB && shift)) begin
      seq.bytes[0] = CH_ESC;
      seq.bytes[1] = CH_LBRK;
      seq.bytes[2] = CH_Z;
      n = 3'd3;
    end else if (have_base) begin
      if (alt) begin
        seq.bytes[n] = CH_ESC; n = n + 1'b1;
      end
      priority if (key == KEY_ENTER) begin
        seq.bytes[n] = CH_CR; n = n + 1'b1;
      end else if (key == KEY_BKSP) begin
        seq.bytes[n] = ctrl ? CH_BS : CH_DEL; n = n + 1'b1;
      end else if (key == KEY_TAB) begin
        seq.bytes[n] = CH_TAB; n = n + 1'b1;
      end else if (key == KEY_ESC) begin
        seq.bytes[n] = CH_ESC; n = n + 1'b1;
      end else if (ctrl && cc[8]) begin
        seq.bytes[n] = cc[7:0]; n = n + 1'b1;
      end else begin
        for (int i = 0; i < MAX_TEXT_BYTES; i++) begin
          if (3'(i) < in_item.text_len) begin
            seq.bytes[n] = in_item.text_bytes[8*i +: 8];
            n = n + 1'b1;
          end
        end
      end
    end else begin
      n = '0;
    end
    seq.len = n;
  end

endmodule

[sv/tke_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key escape encoder sequence queue
// Short first-in first-out queue of built sequences between front and back.
// ----------------------------------------------------------------------------
module tke_queue #(
  parameter int DEPTH = tke_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tke_pkg::seq_t  push_seq,
  input  logic           pop,
  output tke_pkg::seq_t  head_seq,
  output tke_pkg::qstat_t stat
);
  import tke_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  seq_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_seq   = entries[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

endmodule

[sv/tke_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key escape encoder back end
// Sends the bytes of the head sequence one at a time into the output register.
// ----------------------------------------------------------------------------
module tke_back (
  input  logic               clk,
  input  logic               rst,
  input  tke_pkg::seq_t      head_seq,
  input  tke_pkg::qstat_t    stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tke_pkg::out_item_t out_item
);
  import tke_pkg::*;

  logic [SEQ_LEN_W-1:0] idx;
  logic                 load;
  logic                 is_last;

  assign load    = stat.valid && (!out_valid || !out_stall);
  assign is_last = (idx == head_seq.len - 1'b1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_byte  <= head_seq.bytes[idx];
      out_item.last_byte <= is_last;
    end
  end

endmodule

[sv/terminal_key_escape_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key escape encoder
// Turns key events into terminal escape byte sequences, one byte per item out.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall  tke_pkg::in_item_t (one key event)
//   out      output     out_valid/out_stall tke_pkg::out_item_t (one byte)
//   cfg      input      cfg_valid/cfg_ready cfg_data (app_cursor_mode)
//
// A key event is taken while the sequence queue has room; a key of n bytes
// (1 to 7) then leaves at one byte per cycle while the output is not
// stalled, through the single output byte register.
// Reset clears the queue, the byte counter, the output valid and the mode bit.
// A stall on the output holds the byte register; the input stalls only when
// the queue is full.
// ----------------------------------------------------------------------------
module terminal_key_escape_encoder_core #(
  parameter int QUEUE_DEPTH = tke_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tke_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tke_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import tke_pkg::*;

  logic   app_cursor_mode;
  seq_t   front_seq;
  seq_t   head_seq;
  qstat_t stat;
  logic   push;
  logic   pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      app_cursor_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      app_cursor_mode <= cfg_data;
    end
  end

  tke_front u_front (
    .app_cursor_mode (app_cursor_mode),
    .in_item         (in_item),
    .seq             (front_seq)
  );

  assign in_stall = stat.full;
  assign push     = in_valid && !in_stall && (front_seq.len != '0);

  tke_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_seq (front_seq),
    .pop      (pop),
    .head_seq (head_seq),
    .stat     (stat)
  );

  tke_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_seq  (head_seq),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("sequence pushed into a full queue");

  a_push_leaves_entry: assert property (@(posedge clk) disable iff (rst)
    push |=> stat.valid)
    else $error("pushed sequence missing from queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && out_item.last_byte)
    else $error("queue entry retired without a final byte");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> stat.valid)
    else $error("pop from an empty queue");

endmodule
